>>> rtl/hhf_pkg.sv
package hhf_pkg;

   // fixed field widths of the channels
   localparam int INDEX_BITS    = 16;
   localparam int VALUE_BITS    = 16;
   localparam int SIZE_BITS     = 9;
   localparam int STEP_BITS     = 16;
   localparam int COUNT_BITS    = 16;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 16;

   // default sizing of the top level
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int PIXEL_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH     = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT    = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TIME_STEP       = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_ITERATION_COUNT = 4'd3;

   // register reset values
   localparam logic [SIZE_BITS-1:0]  IMAGE_WIDTH_RST     = 9'd256;
   localparam logic [SIZE_BITS-1:0]  IMAGE_HEIGHT_RST    = 9'd256;
   localparam logic [STEP_BITS-1:0]  TIME_STEP_RST       = 16'd8192;
   localparam logic [COUNT_BITS-1:0] ITERATION_COUNT_RST = 16'd100;

   // time_step is Q0.16: products are shifted down by this much, rounding at half
   localparam int FRAC_BITS = STEP_BITS;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef struct packed {
      logic                  start;
      op_type                op;
      logic [INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0] value;
      logic                  hole;
   } eng_cmd_type;

   typedef struct packed {
      logic                  idle;
      logic                  done;
      logic                  run;
      logic [VALUE_BITS-1:0] read_value;
      logic                  read_hole;
      logic [VALUE_BITS-1:0] max_change;
   } eng_res_type;

   typedef struct packed {
      logic lap_en;
      logic mul_en;
   } upd_ctl_type;

endpackage

>>> rtl/hhf_if.sv
interface hhf_req_if import hhf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            operation;
   logic [INDEX_BITS-1:0] pixel_index;
   logic [VALUE_BITS-1:0] pixel_value;
   logic                  is_hole;

   modport source (output valid, operation, pixel_index, pixel_value, is_hole,
                   input ready);
   modport sink   (input valid, operation, pixel_index, pixel_value, is_hole,
                   output ready);
endinterface

interface hhf_rsp_if import hhf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] read_value;
   logic                  read_hole;
   logic [VALUE_BITS-1:0] max_change;

   modport source (output valid, read_value, read_hole, max_change, input ready);
   modport sink   (input valid, read_value, read_hole, max_change, output ready);
endinterface

interface hhf_csr_if import hhf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/harmonic_hole_fill_top.sv
// Hole filling by in-place heat diffusion on a stored image of up to
// MAX_WIDTH x MAX_HEIGHT unsigned Q8.8 pixels. A load item stores one pixel and
// its hole mark (holes are stored as 0), a read item returns a stored pixel and
// its mark, and a run item sweeps the hole pixels in raster order for up to
// iteration_count passes, adding time_step (Q0.16) times the 8-neighbour
// Laplacian with clamped borders, and stops early once a pass changes nothing.
// Every item gives one result carrying the largest change of the last pass of
// the last run. A new item is taken only while no item is in work and the result
// register is empty or being read. A run is paced by the single read port of the
// pixel memory: each hole pixel reads its centre and eight neighbours one at a
// time. The memory is not cleared at reset; read only pixels that were loaded.
// The user must write registers only while no item is in work; the block does not enforce it.
module harmonic_hole_fill_top import hhf_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hhf_req_if.sink    req_bus,
   hhf_rsp_if.source  rsp_bus,
   hhf_csr_if.sink    csr_bus
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [SIZE_BITS-1:0]  width_ff, width_in;
   logic [SIZE_BITS-1:0]  height_ff, height_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] iter_ff, iter_in;
   logic [VALUE_BITS-1:0] last_max_ff, last_max_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_hole_ff, rsp_hole_in;
   logic [VALUE_BITS-1:0] rsp_max_ff, rsp_max_in;

   logic [CW:0]  eff_w;
   logic [RW:0]  eff_h;
   eng_cmd_type  cmd;
   eng_res_type  res;

   // sizes out of range act as the nearest legal size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = (CW+1)'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = (CW+1)'(MAX_WIDTH);
      end else begin
         eff_w = (CW+1)'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = (RW+1)'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = (RW+1)'(MAX_HEIGHT);
      end else begin
         eff_h = (RW+1)'(height_ff);
      end
   end

   assign req_bus.ready = res.idle && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cmd.start = req_bus.valid && req_bus.ready;
      cmd.op    = op_type'(req_bus.operation);
      cmd.index = req_bus.pixel_index;
      cmd.value = req_bus.pixel_value;
      cmd.hole  = req_bus.is_hole;
   end

   hhf_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .time_step  (step_ff),
      .iter_count (iter_ff),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .res        (res)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      step_in   = step_ff;
      iter_in   = iter_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_IMAGE_WIDTH:     width_in  = csr_bus.data[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT:    height_in = csr_bus.data[SIZE_BITS-1:0];
            REG_TIME_STEP:       step_in   = csr_bus.data[STEP_BITS-1:0];
            REG_ITERATION_COUNT: iter_in   = csr_bus.data[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // result register; the engine finishes only when it is empty
   always_comb begin
      last_max_in  = last_max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_hole_in  = rsp_hole_ff;
      rsp_max_in   = rsp_max_ff;
      if (res.done) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res.read_value;
         rsp_hole_in  = res.read_hole;
         rsp_max_in   = res.run ? res.max_change : last_max_ff;
         if (res.run) begin
            last_max_in = res.max_change;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= IMAGE_WIDTH_RST;
         height_ff    <= IMAGE_HEIGHT_RST;
         step_ff      <= TIME_STEP_RST;
         iter_ff      <= ITERATION_COUNT_RST;
         last_max_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         last_max_ff  <= last_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_hole_ff  <= rsp_hole_in;
      rsp_max_ff   <= rsp_max_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_value_ff;
   assign rsp_bus.read_hole  = rsp_hole_ff;
   assign rsp_bus.max_change = rsp_max_ff;

endmodule

>>> rtl/hhf_update.sv
module hhf_update import hhf_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                  clock,
   input  upd_ctl_type           ctl,
   input  logic [PIXEL_BITS-1:0] centre,
   input  logic [PIXEL_BITS+2:0] nbr_sum,
   input  logic [STEP_BITS-1:0]  time_step,
   output logic [PIXEL_BITS-1:0] new_value,
   output logic [PIXEL_BITS-1:0] change
);

   localparam int PB   = PIXEL_BITS;
   localparam int SW   = PB + 3;            // neighbour sum / magnitude
   localparam int LW   = PB + 5;            // signed Laplacian
   localparam int PW   = SW + STEP_BITS;    // product
   localparam int DW   = PW + 1 - FRAC_BITS; // rounded delta
   localparam int NW   = PB + 6;            // signed new value before clamp

   logic signed [LW-1:0] lap;
   logic        [SW-1:0] mag_in;
   logic        [SW-1:0] mag_ff;
   logic                 neg_in;
   logic                 neg_ff;
   logic        [PW-1:0] prod_in;
   logic        [PW-1:0] prod_ff;
   logic        [PW:0]   rounded;
   logic        [DW-1:0] delta;
   logic signed [NW-1:0] cen_s;
   logic signed [NW-1:0] del_s;
   logic signed [NW-1:0] sum_s;

   // Laplacian: neighbour sum minus eight times the centre
   always_comb begin
      lap    = $signed({2'b00, nbr_sum}) - $signed({2'b00, centre, 3'b000});
      neg_in = lap[LW-1];
      mag_in = neg_in ? SW'(-lap) : SW'(lap);
   end

   assign prod_in = PW'(mag_ff) * PW'(time_step);

   always_ff @(posedge clock) begin
      if (ctl.lap_en) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // round half away from zero on the magnitude, apply sign, clamp
   always_comb begin
      rounded = (PW+1)'(prod_ff) + (PW+1)'(1 << (FRAC_BITS - 1));
      delta   = rounded[PW:FRAC_BITS];
      cen_s   = $signed(NW'(centre));
      del_s   = $signed(NW'(delta));
      sum_s   = neg_ff ? cen_s - del_s : cen_s + del_s;
      if (sum_s[NW-1]) begin
         new_value = '0;
      end else if (|sum_s[NW-2:PB]) begin
         new_value = '1;
      end else begin
         new_value = sum_s[PB-1:0];
      end
      change = (new_value > centre) ? new_value - centre : centre - new_value;
   end

endmodule

>>> rtl/hhf_engine.sv
module hhf_engine import hhf_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  eng_cmd_type                      cmd,
   input  logic [STEP_BITS-1:0]             time_step,
   input  logic [COUNT_BITS-1:0]            iter_count,
   input  logic [$clog2(MAX_WIDTH):0]       eff_w,
   input  logic [$clog2(MAX_HEIGHT):0]      eff_h,
   output eng_res_type                      res
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int PB    = PIXEL_BITS;
   localparam int SW    = PB + 3;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_FIN    = 11'b000_0000_0010,
      S_PX_RD  = 11'b000_0000_0100,
      S_PX_CHK = 11'b000_0000_1000,
      S_NB     = 11'b000_0001_0000,
      S_NB_END = 11'b000_0010_0000,
      S_LAP    = 11'b000_0100_0000,
      S_MUL    = 11'b000_1000_0000,
      S_WR     = 11'b001_0000_0000,
      S_NEXT   = 11'b010_0000_0000,
      S_SPARE  = 11'b100_0000_0000
   } state_type;

   // pixel memory: hole mark above the pixel value
   logic [PB:0]   mem_ram [DEPTH];
   logic [PB:0]   mem_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [PB:0]   mem_wd;
   logic [AW-1:0] mem_ra;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic            in_range_ff, in_range_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [COUNT_BITS-1:0] pass_ff, pass_in;
   logic [PB-1:0]   pass_max_ff, pass_max_in;
   logic [PB-1:0]   centre_ff, centre_in;
   logic [SW-1:0]   acc_ff, acc_in;
   logic [2:0]      nb_cnt_ff, nb_cnt_in;
   logic            nb_pend_ff, nb_pend_in;
   logic [CW-1:0]   lf_col_ff, lf_col_in;
   logic [CW-1:0]   rt_col_ff, rt_col_in;
   logic [AW-1:0]   up_base_ff, up_base_in;
   logic [AW-1:0]   dn_base_ff, dn_base_in;

   logic            cmd_in_range;
   logic [AW-1:0]   pix_addr;
   logic [AW-1:0]   nb_row;
   logic [CW-1:0]   nb_col;
   logic [AW-1:0]   nb_addr;
   logic            col_last;
   logic            row_last;
   logic [PB-1:0]   rd_pix;
   logic            rd_hole;
   upd_ctl_type     upd_ctl;
   logic [PB-1:0]   upd_value;
   logic [PB-1:0]   upd_change;

   hhf_update #(.PIXEL_BITS(PIXEL_BITS)) u_update (
      .clock     (clock),
      .ctl       (upd_ctl),
      .centre    (centre_ff),
      .nbr_sum   (acc_ff),
      .time_step (time_step),
      .new_value (upd_value),
      .change    (upd_change)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem_ram[mem_ra];
   end

   assign rd_pix       = mem_rd_ff[PB-1:0];
   assign rd_hole      = mem_rd_ff[PB];
   assign cmd_in_range = 32'(cmd.index) < 32'(DEPTH);
   assign pix_addr     = base_ff + AW'(col_ff);
   assign col_last     = ((CW+1)'(col_ff) + (CW+1)'(1)) == eff_w;
   assign row_last     = ((RW+1)'(row_ff) + (RW+1)'(1)) == eff_h;

   // eight neighbours, borders already clamped into the row/column registers
   always_comb begin
      unique case (nb_cnt_ff)
         3'd0: begin nb_row = base_ff;    nb_col = rt_col_ff; end
         3'd1: begin nb_row = base_ff;    nb_col = lf_col_ff; end
         3'd2: begin nb_row = dn_base_ff; nb_col = col_ff;    end
         3'd3: begin nb_row = up_base_ff; nb_col = col_ff;    end
         3'd4: begin nb_row = dn_base_ff; nb_col = rt_col_ff; end
         3'd5: begin nb_row = dn_base_ff; nb_col = lf_col_ff; end
         3'd6: begin nb_row = up_base_ff; nb_col = lf_col_ff; end
         3'd7: begin nb_row = up_base_ff; nb_col = rt_col_ff; end
      endcase
      nb_addr = nb_row + AW'(nb_col);
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      in_range_in = in_range_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      pass_in     = pass_ff;
      pass_max_in = pass_max_ff;
      centre_in   = centre_ff;
      acc_in      = acc_ff;
      nb_cnt_in   = nb_cnt_ff;
      nb_pend_in  = (state_ff == S_NB);
      lf_col_in   = lf_col_ff;
      rt_col_in   = rt_col_ff;
      up_base_in  = up_base_ff;
      dn_base_in  = dn_base_ff;
      mem_we      = 1'b0;
      mem_wa      = pix_addr;
      mem_wd      = {1'b1, upd_value};
      mem_ra      = pix_addr;
      upd_ctl.lap_en = (state_ff == S_LAP);
      upd_ctl.mul_en = (state_ff == S_MUL);

      if ((state_ff == S_NB || state_ff == S_NB_END) && nb_pend_ff) begin
         acc_in = acc_ff + SW'(rd_pix);
      end

      unique case (state_ff)
         S_IDLE: begin
            mem_ra = AW'(cmd.index);
            if (cmd.start) begin
               op_in       = cmd.op;
               in_range_in = cmd_in_range;
               state_in    = S_FIN;
               unique case (cmd.op)
                  OP_LOAD: begin
                     mem_we = cmd_in_range;
                     mem_wa = AW'(cmd.index);
                     mem_wd = cmd.hole ? {1'b1, {PB{1'b0}}} : {1'b0, PB'(cmd.value)};
                  end
                  OP_RUN: begin
                     col_in      = '0;
                     row_in      = '0;
                     base_in     = '0;
                     pass_in     = '0;
                     pass_max_in = '0;
                     if (iter_count != '0) begin
                        state_in = S_PX_RD;
                     end
                  end
                  OP_READ, OP_NONE: begin
                  end
               endcase
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         S_PX_RD: begin
            state_in = S_PX_CHK;
         end
         S_PX_CHK: begin
            if (rd_hole) begin
               centre_in  = rd_pix;
               acc_in     = '0;
               nb_cnt_in  = '0;
               lf_col_in  = (col_ff == '0) ? col_ff : col_ff - CW'(1);
               rt_col_in  = col_last ? col_ff : col_ff + CW'(1);
               up_base_in = (row_ff == '0) ? base_ff : base_ff - AW'(eff_w);
               dn_base_in = row_last ? base_ff : base_ff + AW'(eff_w);
               state_in   = S_NB;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NB: begin
            mem_ra    = nb_addr;
            nb_cnt_in = nb_cnt_ff + 3'd1;
            if (nb_cnt_ff == 3'd7) begin
               state_in = S_NB_END;
            end
         end
         S_NB_END: begin
            state_in = S_LAP;
         end
         S_LAP: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_WR;
         end
         S_WR: begin
            mem_we = 1'b1;
            if (upd_change > pass_max_ff) begin
               pass_max_in = upd_change;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            state_in = S_PX_RD;
            if (!col_last) begin
               col_in = col_ff + CW'(1);
            end else begin
               col_in = '0;
               if (!row_last) begin
                  row_in  = row_ff + RW'(1);
                  base_in = base_ff + AW'(eff_w);
               end else if (pass_max_ff == '0 || pass_ff + 16'd1 == iter_count) begin
                  // fixed point reached or last pass done
                  state_in = S_FIN;
               end else begin
                  row_in      = '0;
                  base_in     = '0;
                  pass_in     = pass_ff + 16'd1;
                  pass_max_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         nb_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         nb_pend_ff <= nb_pend_in;
      end
      op_ff       <= op_in;
      in_range_ff <= in_range_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      pass_ff     <= pass_in;
      pass_max_ff <= pass_max_in;
      centre_ff   <= centre_in;
      acc_ff      <= acc_in;
      nb_cnt_ff   <= nb_cnt_in;
      lf_col_ff   <= lf_col_in;
      rt_col_ff   <= rt_col_in;
      up_base_ff  <= up_base_in;
      dn_base_ff  <= dn_base_in;
   end

   // for items other than a run, in S_FIN the read data still holds the word addressed when the item came in
   always_comb begin
      res.idle       = (state_ff == S_IDLE);
      res.done       = (state_ff == S_FIN);
      res.run        = (op_ff == OP_RUN);
      res.read_value = '0;
      res.read_hole  = 1'b0;
      res.max_change = VALUE_BITS'(pass_max_ff);
      if (op_ff == OP_READ && in_range_ff) begin
         res.read_value = VALUE_BITS'(rd_pix);
         res.read_hole  = rd_hole;
      end
   end

endmodule
